### hdl/dpp_pkg.sv
`default_nettype none

package dpp_pkg;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 8;
  localparam logic [CfgIdxW-1:0] RegInclTrig  = 8'd0;
  localparam logic [CfgIdxW-1:0] RegAzimTrig  = 8'd1;
  localparam logic [CfgIdxW-1:0] RegRollTrig  = 8'd2;
  localparam logic [CfgIdxW-1:0] RegFrameMinX = 8'd3;
  localparam logic [CfgIdxW-1:0] RegFrameMinY = 8'd4;
  localparam logic [CfgIdxW-1:0] RegPpuX      = 8'd5;
  localparam logic [CfgIdxW-1:0] RegPpuY      = 8'd6;
  localparam logic [CfgIdxW-1:0] RegDims      = 8'd7;

  // Reset values
  localparam logic signed [31:0] QOne      = 32'sh4000_0000;  // 1.0 in Q1.30
  localparam logic [31:0]        PpuReset  = 32'h0001_0000;   // 1.0 in Q16.16
  localparam logic [15:0]        DimReset  = 16'd1024;

  // Bound on the intermediate rotation result, Q18.16
  localparam logic signed [37:0] RotLimit  = 38'sd4294967295;

  typedef struct packed {
    logic signed [31:0] cos_inc;
    logic signed [31:0] sin_inc;
    logic signed [31:0] cos_az;
    logic signed [31:0] sin_az;
    logic signed [31:0] cos_roll;
    logic signed [31:0] sin_roll;
    logic signed [31:0] min_x;
    logic signed [31:0] min_y;
    logic [31:0]        ppu_x;
    logic [31:0]        ppu_y;
    logic [15:0]        width;
    logic [15:0]        height;
  } cfg_t;

  // Roll products, floored to Q20.16
  typedef struct packed {
    logic signed [35:0] crx;
    logic signed [35:0] sry;
    logic signed [35:0] srx;
    logic signed [35:0] cry;
  } rot_t;

  function automatic logic signed [33:0] clamp_q(input logic signed [37:0] v);
    logic signed [37:0] r;
    begin
      if (v > RotLimit) begin
        r = RotLimit;
      end else if (v < -RotLimit) begin
        r = -RotLimit;
      end else begin
        r = v;
      end
      return r[33:0];
    end
  endfunction

endpackage

`default_nettype wire

### hdl/dpp_cfg_regs.sv
`default_nettype none

module dpp_cfg_regs (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [dpp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [63:0]                  cfg_data_i,
  output dpp_pkg::cfg_t                     cfg_o
);
  import dpp_pkg::*;

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // Unknown indexes drop the write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cos_inc  <= QOne;
      cfg_q.sin_inc  <= '0;
      cfg_q.cos_az   <= QOne;
      cfg_q.sin_az   <= '0;
      cfg_q.cos_roll <= QOne;
      cfg_q.sin_roll <= '0;
      cfg_q.min_x    <= '0;
      cfg_q.min_y    <= '0;
      cfg_q.ppu_x    <= PpuReset;
      cfg_q.ppu_y    <= PpuReset;
      cfg_q.width    <= DimReset;
      cfg_q.height   <= DimReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegInclTrig: begin
          cfg_q.cos_inc <= cfg_data_i[63:32];
          cfg_q.sin_inc <= cfg_data_i[31:0];
        end
        RegAzimTrig: begin
          cfg_q.cos_az <= cfg_data_i[63:32];
          cfg_q.sin_az <= cfg_data_i[31:0];
        end
        RegRollTrig: begin
          cfg_q.cos_roll <= cfg_data_i[63:32];
          cfg_q.sin_roll <= cfg_data_i[31:0];
        end
        RegFrameMinX: cfg_q.min_x <= cfg_data_i[31:0];
        RegFrameMinY: cfg_q.min_y <= cfg_data_i[31:0];
        RegPpuX:      cfg_q.ppu_x <= cfg_data_i[31:0];
        RegPpuY:      cfg_q.ppu_y <= cfg_data_i[31:0];
        RegDims: begin
          cfg_q.width  <= cfg_data_i[31:16];
          cfg_q.height <= cfg_data_i[15:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### hdl/dpp_rotate.sv
`default_nettype none

module dpp_rotate (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire dpp_pkg::cfg_t       cfg_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic signed [31:0]  pos_x_i,
  input  wire logic signed [31:0]  pos_y_i,
  input  wire logic signed [31:0]  pos_z_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output dpp_pkg::rot_t            out_o
);
  import dpp_pkg::*;

  localparam int unsigned NumStg = 4;
  localparam logic signed [33:0] MinQ = 34'sh2_0000_0000;

  logic [NumStg-1:0] vld_q;
  logic [NumStg-1:0] en;

  always_comb begin
    en[NumStg-1] = !vld_q[NumStg-1] || out_ready_i;
    for (int k = NumStg - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= in_valid_i;
      for (int k = 1; k < NumStg; k++) begin
        if (en[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[NumStg-1];

  // Stage 1: azimuth and inclination products
  logic signed [63:0] ay_p, ax_p, iz_p, cc_p, sc_p;
  logic signed [33:0] ay_q, ax_q, iz_q, cc_q, sc_q;
  logic signed [31:0] x_q, y_q;

  assign ay_p = 64'(cfg_i.cos_az) * 64'(pos_y_i);
  assign ax_p = 64'(cfg_i.sin_az) * 64'(pos_x_i);
  assign iz_p = 64'(cfg_i.sin_inc) * 64'(pos_z_i);
  assign cc_p = 64'(cfg_i.cos_az) * 64'(cfg_i.cos_inc);
  assign sc_p = 64'(cfg_i.sin_az) * 64'(cfg_i.cos_inc);

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      ay_q <= ay_p[63:30];
      ax_q <= ax_p[63:30];
      iz_q <= iz_p[63:30];
      cc_q <= cc_p[63:30];
      sc_q <= sc_p[63:30];
      x_q  <= pos_x_i;
      y_q  <= pos_y_i;
    end
  end

  // Stage 2: finish xpp, form the combined-angle products
  logic signed [65:0] cx_p, sy_p;
  logic signed [37:0] xsum;
  logic signed [33:0] xpp2_q, iz2_q;
  logic signed [35:0] cx_q, sy_q;

  assign cx_p = 66'(cc_q) * 66'(x_q);
  assign sy_p = 66'(sc_q) * 66'(y_q);
  assign xsum = 38'(ay_q) - 38'(ax_q);

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      xpp2_q <= clamp_q(xsum);
      iz2_q  <= iz_q;
      cx_q   <= cx_p[65:30];
      sy_q   <= sy_p[65:30];
    end
  end

  // Stage 3: finish ypp
  logic signed [37:0] ysum;
  logic signed [33:0] xpp3_q, ypp3_q;

  assign ysum = 38'(iz2_q) - 38'(cx_q) - 38'(sy_q);

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      xpp3_q <= xpp2_q;
      ypp3_q <= clamp_q(ysum);
    end
  end

  // Stage 4: roll products
  logic signed [65:0] crx_p, sry_p, srx_p, cry_p;
  rot_t rot_q;

  assign crx_p = 66'(cfg_i.cos_roll) * 66'(xpp3_q);
  assign sry_p = 66'(cfg_i.sin_roll) * 66'(ypp3_q);
  assign srx_p = 66'(cfg_i.sin_roll) * 66'(xpp3_q);
  assign cry_p = 66'(cfg_i.cos_roll) * 66'(ypp3_q);

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      rot_q.crx <= crx_p[65:30];
      rot_q.sry <= sry_p[65:30];
      rot_q.srx <= srx_p[65:30];
      rot_q.cry <= cry_p[65:30];
    end
  end

  assign out_o = rot_q;

  // The clamp never leaves the most negative 34-bit code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[2] |-> (xpp3_q != MinQ) && (ypp3_q != MinQ))
    else $error("rotation result outside clamp range");

  // A stalled output stage keeps its word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NumStg-1] && !out_ready_i |=> vld_q[NumStg-1] && $stable(rot_q))
    else $error("rotation output lost during stall");

endmodule

`default_nettype wire

### hdl/dpp_pixel.sv
`default_nettype none

module dpp_pixel (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire dpp_pkg::cfg_t  cfg_i,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire dpp_pkg::rot_t  in_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output logic                on_detector_o,
  output logic [15:0]         column_o,
  output logic [15:0]         row_o,
  output logic [31:0]         pixel_index_o
);
  import dpp_pkg::*;

  localparam int unsigned NumStg = 4;

  logic [NumStg-1:0] vld_q;
  logic [NumStg-1:0] en;

  always_comb begin
    en[NumStg-1] = !vld_q[NumStg-1] || out_ready_i;
    for (int k = NumStg - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= in_valid_i;
      for (int k = 1; k < NumStg; k++) begin
        if (en[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[NumStg-1];

  // Stage 1: finish roll and subtract the frame origin
  logic signed [37:0] dx_w, dy_w;
  logic signed [37:0] dx_q, dy_q;

  assign dx_w = 38'(in_i.crx) - 38'(in_i.sry) - 38'(cfg_i.min_x);
  assign dy_w = 38'(in_i.srx) + 38'(in_i.cry) - 38'(cfg_i.min_y);

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      dx_q <= dx_w;
      dy_q <= dy_w;
    end
  end

  // Stage 2: scale to pixels, upper and lower halves of the offset apart
  logic [36:0] hx_p, hy_p;
  logic [63:0] lx_p, ly_p;
  logic [36:0] hx_q, hy_q;
  logic [31:0] lx_q, ly_q;
  logic        negx_q, negy_q, zx_q, zy_q;

  assign hx_p = 37'(dx_q[36:32]) * 37'(cfg_i.ppu_x);
  assign hy_p = 37'(dy_q[36:32]) * 37'(cfg_i.ppu_y);
  assign lx_p = 64'(dx_q[31:0]) * 64'(cfg_i.ppu_x);
  assign ly_p = 64'(dy_q[31:0]) * 64'(cfg_i.ppu_y);

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      hx_q   <= hx_p;
      hy_q   <= hy_p;
      lx_q   <= lx_p[63:32];
      ly_q   <= ly_p[63:32];
      negx_q <= dx_q[37];
      negy_q <= dy_q[37];
      zx_q   <= (cfg_i.ppu_x == '0);
      zy_q   <= (cfg_i.ppu_y == '0);
    end
  end

  // Stage 3: sum halves, bounds-check
  logic [37:0] idxx, idxy;
  logic        okx, oky, inx, iny, hit;
  logic        on3_q;
  logic [15:0] col3_q, row3_q;

  assign idxx = 38'(hx_q) + 38'(lx_q);
  assign idxy = 38'(hy_q) + 38'(ly_q);
  // A negative offset hits only with a zero scale, and then at index zero
  assign okx  = negx_q ? zx_q : 1'b1;
  assign oky  = negy_q ? zy_q : 1'b1;
  assign inx  = negx_q ? (cfg_i.width != '0)  : (idxx < {22'd0, cfg_i.width});
  assign iny  = negy_q ? (cfg_i.height != '0) : (idxy < {22'd0, cfg_i.height});
  assign hit  = okx && oky && inx && iny;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      on3_q  <= hit;
      col3_q <= (hit && !negx_q) ? idxx[15:0] : '0;
      row3_q <= (hit && !negy_q) ? idxy[15:0] : '0;
    end
  end

  // Stage 4: linear index; a miss carries zero column and row, so zero here too
  logic [31:0] pix_w;
  logic        on_q;
  logic [15:0] col_q, row_q;
  logic [31:0] pix_q;

  assign pix_w = {16'd0, col3_q} + (32'(cfg_i.width) * 32'(row3_q));

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      on_q  <= on3_q;
      col_q <= col3_q;
      row_q <= row3_q;
      pix_q <= pix_w;
    end
  end

  assign on_detector_o = on_q;
  assign column_o      = col_q;
  assign row_o         = row_q;
  assign pixel_index_o = pix_q;

  // A miss reports all-zero fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NumStg-1] && !on_q |-> (col_q == '0) && (row_q == '0) && (pix_q == '0))
    else $error("miss with nonzero pixel fields");

  // A held middle stage keeps its valid bit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[2] && !en[2] |=> vld_q[2] && $stable(col3_q) && $stable(row3_q))
    else $error("bounds stage dropped a word during stall");

endmodule

`default_nettype wire

### hdl/detector_pixel_projection.sv
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata: pos_x, pos_y, pos_z
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: column, row, pixel_index;
//                                              tuser: on_detector
// cfg       in   cfg_valid_i/cfg_ready_o       cfg_index_i, cfg_data_i
//
// Takes one word per clock while m_axis_tready does not stall it; each word passes
// through eight multiply and add stages (four rotate, four pixel) to m_axis.
// Each stage carries a valid bit and loads only when the stage after it can
// take its word, so a stall at m_axis backs up stage by stage and bubbles fill.
// Reset clears every valid bit and loads the configuration defaults:
// identity angles, zero frame origin, one pixel per unit, 1024 x 1024 pixels.
// cfg_ready_o is always high; write registers only while no word is in flight.
`default_nettype none

module detector_pixel_projection (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // pos_x [31:0], pos_y [63:32], pos_z [95:64]
  input  wire logic [95:0]                 s_axis_tdata,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  // column [15:0], row [31:16], pixel_index [63:32]
  output logic [63:0]                      m_axis_tdata,
  // on_detector [0]
  output logic                             m_axis_tuser,
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [dpp_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [63:0]                 cfg_data_i
);
  import dpp_pkg::*;

  cfg_t        cfg;
  rot_t        rot;
  logic        rot_valid, rot_ready;
  logic [15:0] column, row;
  logic [31:0] pixel_index;
  logic        on_detector;

  dpp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Azimuth/inclination then roll
  dpp_rotate u_rotate (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .pos_x_i     (s_axis_tdata[31:0]),
    .pos_y_i     (s_axis_tdata[63:32]),
    .pos_z_i     (s_axis_tdata[95:64]),
    .out_valid_o (rot_valid),
    .out_ready_i (rot_ready),
    .out_o       (rot)
  );

  // Origin offset, pixel scaling, bounds check, linear index
  dpp_pixel u_pixel (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_valid_i    (rot_valid),
    .in_ready_o    (rot_ready),
    .in_i          (rot),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .on_detector_o (on_detector),
    .column_o      (column),
    .row_o         (row),
    .pixel_index_o (pixel_index)
  );

  assign m_axis_tdata = {pixel_index, row, column};
  assign m_axis_tuser = on_detector;

  // An empty output stage means the whole pipeline can advance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input held while output stage is empty");

endmodule

`default_nettype wire
